// ===== sv/pbei_pkg.sv =====
package pbei_pkg;

  // fixed widths
  localparam int CW    = 32;   // input coordinate
  localparam int AW    = 38;   // short multiplier operand (signed)
  localparam int NW    = 68;   // normal component / long operand (signed)
  localparam int DIGW  = 17;   // digit of the long operand per mac cycle
  localparam int NDIG  = NW / DIGW;
  localparam int ACCW  = 108;  // mac accumulator
  localparam int QW    = 38;   // quotient bits kept by the divider
  localparam int RW    = 112;  // divider remainder
  localparam int VW    = 40;   // solved coordinate
  localparam int PW    = 28;   // point field
  localparam int SZW   = 13;   // size register
  localparam int NCAND = 12;   // box edges

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] v3_x;
    logic signed [CW-1:0] v3_y;
    logic signed [CW-1:0] v3_z;
  } plane_in_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_COPLANAR = 2'd1,
    ST_FEW_POINTS   = 2'd2
  } status_e;

  typedef struct packed {
    logic [PW-1:0] point_x;
    logic [PW-1:0] point_y;
    logic [PW-1:0] point_z;
    logic          point_valid;
    status_e       status;
    logic          last;
  } result_t;

  // classified plane handed from front to back
  typedef struct packed {
    logic signed [CW-1:0] p1_x;
    logic signed [CW-1:0] p1_y;
    logic signed [CW-1:0] p1_z;
    logic signed [NW-1:0] n_x;
    logic signed [NW-1:0] n_y;
    logic signed [NW-1:0] n_z;
    logic                 coplanar;
  } plane_t;

  // init + a0*b0 +/- a1*b1
  typedef struct packed {
    logic signed [ACCW-1:0] init;
    logic signed [AW-1:0]   a0;
    logic signed [NW-1:0]   b0;
    logic signed [AW-1:0]   a1;
    logic signed [NW-1:0]   b1;
    logic                   sub;
  } mac_req_t;

  typedef struct packed {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] z;
  } point_t;

  // corner select per edge: {first fixed axis at max, second fixed axis at max}
  localparam logic [1:0] EDGE_SEL [NCAND] = '{
    2'b01, 2'b11, 2'b00, 2'b10,
    2'b00, 2'b11, 2'b01, 2'b10,
    2'b00, 2'b10, 2'b11, 2'b01
  };

  function automatic logic [AW-1:0] abs_a(logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  function automatic logic [NW-1:0] abs_n(logic signed [NW-1:0] v);
    return v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  function automatic logic [ACCW-1:0] abs_acc(logic signed [ACCW-1:0] v);
    return v[ACCW-1] ? ACCW'(-v) : ACCW'(v);
  endfunction

endpackage

// ===== sv/pbei_mac.sv =====
module pbei_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  pbei_pkg::mac_req_t             req_i,
  output logic                           done_o,
  output logic [pbei_pkg::ACCW-1:0]      res_o
);

  localparam int DGW = $clog2(pbei_pkg::NDIG);

  logic                           busy_q, term_q, done_q;
  logic [DGW-1:0]                 dig_q;
  logic [pbei_pkg::AW-1:0]        am_q [2];
  logic [pbei_pkg::NW-1:0]        bm_q [2];
  logic                           neg_q [2];
  logic [pbei_pkg::ACCW-1:0]      acc_q, acc_d, sh;
  logic [pbei_pkg::DIGW-1:0]      digit;
  logic [pbei_pkg::AW+pbei_pkg::DIGW-1:0] pp;

  // one digit partial product per cycle, accumulated with sign
  always_comb begin
    digit = bm_q[term_q][dig_q*pbei_pkg::DIGW +: pbei_pkg::DIGW];
    pp    = am_q[term_q] * digit;
    sh    = pbei_pkg::ACCW'(pp) << (pbei_pkg::DIGW * dig_q);
    acc_d = neg_q[term_q] ? acc_q - sh : acc_q + sh;
  end

  // sequencer over two terms of NDIG digits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      term_q <= 1'b0;
      dig_q  <= '0;
    end else begin
      done_q <= busy_q && term_q && (dig_q == DGW'(pbei_pkg::NDIG - 1));
      if (go_i && !busy_q) begin
        busy_q   <= 1'b1;
        term_q   <= 1'b0;
        dig_q    <= '0;
        acc_q    <= req_i.init;
        am_q[0]  <= pbei_pkg::abs_a(req_i.a0);
        bm_q[0]  <= pbei_pkg::abs_n(req_i.b0);
        neg_q[0] <= req_i.a0[pbei_pkg::AW-1] ^ req_i.b0[pbei_pkg::NW-1];
        am_q[1]  <= pbei_pkg::abs_a(req_i.a1);
        bm_q[1]  <= pbei_pkg::abs_n(req_i.b1);
        neg_q[1] <= req_i.a1[pbei_pkg::AW-1] ^ req_i.b1[pbei_pkg::NW-1] ^ req_i.sub;
      end else if (busy_q) begin
        acc_q <= acc_d;
        if (dig_q == DGW'(pbei_pkg::NDIG - 1)) begin
          dig_q <= '0;
          if (term_q) begin
            busy_q <= 1'b0;
          end else begin
            term_q <= 1'b1;
          end
        end else begin
          dig_q <= dig_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// ===== sv/pbei_front.sv =====
module pbei_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  pbei_pkg::plane_in_t   plane_i,
  output logic                  busy_o,
  output logic                  push_o,
  output pbei_pkg::plane_t      rec_o,
  input  logic                  full_i
);

  typedef enum logic [1:0] {F_IDLE, F_RUN, F_PUSH} state_e;

  state_e                        state_q;
  logic [2:0]                    step_q;
  logic                          issued_q, copl_q;
  pbei_pkg::plane_in_t           v_q;
  logic signed [pbei_pkg::NW-1:0]   nx_q, ny_q, nz_q;
  logic signed [pbei_pkg::ACCW-1:0] pf_q;
  logic signed [32:0]            ax, ay, az, bx, by, bz, dx, dy, dz;
  pbei_pkg::mac_req_t            req;
  logic                          go, mac_done;
  logic [pbei_pkg::ACCW-1:0]     mac_res;

  // edge vectors from vertex 1
  always_comb begin
    ax = 33'(v_q.v2_x) - 33'(v_q.v1_x);
    ay = 33'(v_q.v2_y) - 33'(v_q.v1_y);
    az = 33'(v_q.v2_z) - 33'(v_q.v1_z);
    bx = 33'(v_q.v3_x) - 33'(v_q.v1_x);
    by = 33'(v_q.v3_y) - 33'(v_q.v1_y);
    bz = 33'(v_q.v3_z) - 33'(v_q.v1_z);
    dx = 33'(v_q.v0_x) - 33'(v_q.v1_x);
    dy = 33'(v_q.v0_y) - 33'(v_q.v1_y);
    dz = 33'(v_q.v0_z) - 33'(v_q.v1_z);
  end

  // operand decoder: three normal components, then the coplanar sum
  always_comb begin
    req = '0;
    unique case (step_q)
      3'd0: begin
        req.a0 = pbei_pkg::AW'(ay); req.b0 = pbei_pkg::NW'(bz);
        req.a1 = pbei_pkg::AW'(az); req.b1 = pbei_pkg::NW'(by); req.sub = 1'b1;
      end
      3'd1: begin
        req.a0 = pbei_pkg::AW'(ax); req.b0 = pbei_pkg::NW'(bz);
        req.a1 = pbei_pkg::AW'(bx); req.b1 = pbei_pkg::NW'(az); req.sub = 1'b1;
      end
      3'd2: begin
        req.a0 = pbei_pkg::AW'(ax); req.b0 = pbei_pkg::NW'(by);
        req.a1 = pbei_pkg::AW'(bx); req.b1 = pbei_pkg::NW'(ay); req.sub = 1'b1;
      end
      3'd3: begin
        req.a0 = pbei_pkg::AW'(dx); req.b0 = nx_q;
        req.a1 = pbei_pkg::AW'(dy); req.b1 = ny_q; req.sub = 1'b1;
      end
      3'd4: begin
        req.init = pf_q;
        req.a0 = pbei_pkg::AW'(dz); req.b0 = nz_q;
      end
      default: req = '0;
    endcase
  end

  assign go = (state_q == F_RUN) && !issued_q;

  pbei_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .req_i  (req),
    .done_o (mac_done),
    .res_o  (mac_res)
  );

  // control and plane capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      step_q   <= '0;
      issued_q <= 1'b0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (start_i) begin
            v_q      <= plane_i;
            step_q   <= '0;
            issued_q <= 1'b0;
            state_q  <= F_RUN;
          end
        end
        F_RUN: begin
          if (go) issued_q <= 1'b1;
          if (mac_done) begin
            issued_q <= 1'b0;
            step_q   <= step_q + 1'b1;
            case (step_q)
              3'd0: nx_q <= pbei_pkg::NW'(mac_res);
              3'd1: ny_q <= pbei_pkg::NW'(mac_res);
              3'd2: nz_q <= pbei_pkg::NW'(mac_res);
              3'd3: pf_q <= mac_res;
              default: begin
                copl_q  <= (mac_res == '0);
                state_q <= F_PUSH;
              end
            endcase
          end
        end
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    rec_o.p1_x     = v_q.v1_x;
    rec_o.p1_y     = v_q.v1_y;
    rec_o.p1_z     = v_q.v1_z;
    rec_o.n_x      = nx_q;
    rec_o.n_y      = ny_q;
    rec_o.n_z      = nz_q;
    rec_o.coplanar = copl_q;
  end

  assign push_o = (state_q == F_PUSH) && !full_i;
  assign busy_o = (state_q != F_IDLE);

endmodule

// ===== sv/pbei_queue.sv =====
module pbei_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pbei_pkg::plane_t  rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pbei_pkg::plane_t  head_o
);

  pbei_pkg::plane_t mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  // two-entry request queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        mem_q[wr_q] <= rec_i;
        wr_q        <= ~wr_q;
      end
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

endmodule

// ===== sv/pbei_back.sv =====
module pbei_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pbei_pkg::SZW-1:0]      size_x_i,
  input  logic [pbei_pkg::SZW-1:0]      size_y_i,
  input  logic [pbei_pkg::SZW-1:0]      size_z_i,
  input  logic                          empty_i,
  input  pbei_pkg::plane_t              head_i,
  output logic                          pop_o,
  output logic                          result_valid_o,
  output pbei_pkg::result_t             result_o
);

  localparam int AW = pbei_pkg::AW;
  localparam int NW = pbei_pkg::NW;
  localparam int RW = pbei_pkg::RW;
  localparam int VW = pbei_pkg::VW;
  localparam int PW = pbei_pkg::PW;
  localparam int QW = pbei_pkg::QW;
  localparam int SW = $clog2(QW);
  localparam int CW_W = pbei_pkg::CW;

  typedef enum logic [2:0] {B_IDLE, B_SETUP, B_MUL, B_PREP, B_DIV, B_FIN, B_EMIT} state_e;

  state_e                  state_q;
  pbei_pkg::plane_t        rec_q;
  logic                    nocop_q, neg_q, ovf_q, res_valid_q;
  logic [3:0]              cand_q, cnt_q, ecnt_q;
  logic [SW-1:0]           dstep_q;
  pbei_pkg::point_t        pts_q [pbei_pkg::NCAND];
  logic [RW-1:0]           rem_q, dsh_q;
  logic [NW:0]             d2_q;
  logic [QW-1:0]           q_q;
  pbei_pkg::result_t       res_q;

  logic [AW-1:0]           mx, my, mz, c1, c2, bnd;
  logic [1:0]              grp, sel;
  logic signed [NW-1:0]    den;
  logic signed [CW_W-1:0]  base;
  logic                    ends, go, mac_done, ge, keep, last_cand;
  pbei_pkg::mac_req_t      req;
  logic [pbei_pkg::ACCW-1:0] mac_res;
  logic signed [VW-1:0]    qs, v, vb;
  pbei_pkg::point_t        pt;

  // box extent per axis in fixed point, size saturated to 1..4096
  function automatic logic [AW-1:0] edge_max(logic [pbei_pkg::SZW-1:0] s);
    logic [pbei_pkg::SZW-1:0] t;
    t = s;
    if (t == '0) t = pbei_pkg::SZW'(1);
    if (t > pbei_pkg::SZW'(4096)) t = pbei_pkg::SZW'(4096);
    return AW'(t - 1'b1) << FRAC_BITS;
  endfunction

  always_comb begin
    mx = edge_max(size_x_i);
    my = edge_max(size_y_i);
    mz = edge_max(size_z_i);
  end

  // candidate decode: fixed corner coordinates and solve operands
  always_comb begin
    grp  = cand_q[3:2];
    sel  = pbei_pkg::EDGE_SEL[cand_q];
    req  = '0;
    c1   = '0;
    c2   = '0;
    den  = '0;
    base = '0;
    bnd  = '0;
    ends = 1'b0;
    case (grp)
      2'd0: begin
        c1 = sel[1] ? my : '0;
        c2 = sel[0] ? mz : '0;
        req.a0 = c1 - AW'(rec_q.p1_y); req.b0 = rec_q.n_y;
        req.a1 = c2 - AW'(rec_q.p1_z); req.b1 = rec_q.n_z; req.sub = 1'b1;
        den = rec_q.n_x; base = rec_q.p1_x; bnd = mx; ends = 1'b1;
      end
      2'd1: begin
        c1 = sel[1] ? mx : '0;
        c2 = sel[0] ? mz : '0;
        req.a0 = c1 - AW'(rec_q.p1_x); req.b0 = rec_q.n_x;
        req.a1 = c2 - AW'(rec_q.p1_z); req.b1 = rec_q.n_z; req.sub = 1'b0;
        den = rec_q.n_y; base = rec_q.p1_y; bnd = my;
        ends = (rec_q.n_x == '0);
      end
      2'd2: begin
        c1 = sel[1] ? mx : '0;
        c2 = sel[0] ? my : '0;
        req.a0 = c2 - AW'(rec_q.p1_y); req.b0 = rec_q.n_y;
        req.a1 = c1 - AW'(rec_q.p1_x); req.b1 = rec_q.n_x; req.sub = 1'b1;
        den = rec_q.n_z; base = rec_q.p1_z; bnd = mz;
        ends = (rec_q.n_x == '0) && (rec_q.n_y == '0);
      end
      default: ;
    endcase
  end

  assign go        = (state_q == B_SETUP) && (den != '0);
  assign last_cand = (cand_q == 4'(pbei_pkg::NCAND - 1));

  pbei_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .req_i  (req),
    .done_o (mac_done),
    .res_o  (mac_res)
  );

  // restoring divide step and acceptance of the solved coordinate
  always_comb begin
    ge   = (rem_q >= dsh_q);
    qs   = VW'(q_q);
    v    = (neg_q ? -qs : qs) + VW'(base);
    vb   = VW'(bnd);
    keep = !ovf_q && (((v > 0) && (v < vb)) || (((v == 0) || (v == vb)) && ends));
    pt   = '0;
    case (grp)
      2'd0:    pt = '{x: PW'(v), y: PW'(c1), z: PW'(c2)};
      2'd1:    pt = '{x: PW'(c1), y: PW'(v), z: PW'(c2)};
      default: pt = '{x: PW'(c1), y: PW'(c2), z: PW'(v)};
    endcase
  end

  assign pop_o = (state_q == B_IDLE) && !empty_i;

  // candidate sequencer and result emission
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
      cand_q      <= '0;
      cnt_q       <= '0;
      ecnt_q      <= '0;
      dstep_q     <= '0;
    end else begin
      res_valid_q <= (state_q == B_EMIT);
      unique case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            rec_q   <= head_i;
            nocop_q <= !head_i.coplanar;
            cand_q  <= '0;
            cnt_q   <= '0;
            ecnt_q  <= '0;
            state_q <= head_i.coplanar ? B_SETUP : B_EMIT;
          end
        end
        B_SETUP: begin
          if (den != '0) begin
            state_q <= B_MUL;
          end else if (last_cand) begin
            state_q <= B_EMIT;
          end else begin
            cand_q <= cand_q + 1'b1;
          end
        end
        B_MUL: begin
          if (mac_done) begin
            neg_q   <= mac_res[pbei_pkg::ACCW-1] ^ den[NW-1];
            rem_q   <= RW'({pbei_pkg::abs_acc(mac_res), 1'b0})
                       + RW'(pbei_pkg::abs_n(den));
            d2_q    <= {pbei_pkg::abs_n(den), 1'b0};
            state_q <= B_PREP;
          end
        end
        B_PREP: begin
          ovf_q   <= (rem_q >= (RW'(d2_q) << QW));
          dsh_q   <= RW'(d2_q) << (QW - 1);
          dstep_q <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          if (ge) rem_q <= rem_q - dsh_q;
          q_q   <= {q_q[QW-2:0], ge};
          dsh_q <= dsh_q >> 1;
          if (dstep_q == SW'(QW - 1)) begin
            state_q <= B_FIN;
          end else begin
            dstep_q <= dstep_q + 1'b1;
          end
        end
        B_FIN: begin
          if (keep) begin
            pts_q[cnt_q] <= pt;
            cnt_q        <= cnt_q + 1'b1;
          end
          if (last_cand) begin
            state_q <= B_EMIT;
          end else begin
            cand_q  <= cand_q + 1'b1;
            state_q <= B_SETUP;
          end
        end
        B_EMIT: begin
          if (nocop_q || (cnt_q == '0)) begin
            res_q.point_x     <= '0;
            res_q.point_y     <= '0;
            res_q.point_z     <= '0;
            res_q.point_valid <= 1'b0;
            res_q.last        <= 1'b1;
            res_q.status      <= nocop_q ? pbei_pkg::ST_NOT_COPLANAR
                                         : pbei_pkg::ST_FEW_POINTS;
            state_q           <= B_IDLE;
          end else begin
            res_q.point_x     <= pts_q[ecnt_q].x;
            res_q.point_y     <= pts_q[ecnt_q].y;
            res_q.point_z     <= pts_q[ecnt_q].z;
            res_q.point_valid <= 1'b1;
            res_q.status      <= (cnt_q >= 4'd3) ? pbei_pkg::ST_OK
                                                 : pbei_pkg::ST_FEW_POINTS;
            res_q.last        <= (ecnt_q == cnt_q - 1'b1);
            if (ecnt_q == cnt_q - 1'b1) begin
              state_q <= B_IDLE;
            end else begin
              ecnt_q <= ecnt_q + 1'b1;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== sv/plane_box_edge_intersection.sv =====
// Plane / volume box edge intersection.
// Request channel: a plane (four slice-rectangle vertices, signed fixed point)
// is taken at a clock edge where start is high and busy is low. Results leave
// on result_o, one per cycle, marked by result_valid_o; the receiver cannot
// stall, so each result is valid for exactly one cycle.
// Per request: one result if the vertices are not coplanar or no edge is hit,
// else one result per intersection point, the final one flagged with last.
// The front end forms the normal and the coplanar test on its own 38x17-bit
// multiply-accumulate in five passes; busy stays high until the request is
// pushed into a two-entry queue. The back end solves each of the twelve box
// edges whose normal component is nonzero (setup, mac, compare, restoring
// divide and accept), skips the others, then emits the points; the back-end
// divider sets the sustained rate. The front accepts a new plane while the
// back end still works on earlier ones.
// Box sizes are written over the APB port (0x0, 0x4, 0x8); the user must
// write them only while idle, as the block itself does not enforce it.
// Reset clears both sides and the queue and sets each box size to 512.
module plane_box_edge_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  input  pbei_pkg::plane_in_t           plane_i,
  output logic                          busy,
  output logic                          result_valid_o,
  output pbei_pkg::result_t             result_o
);

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  logic [pbei_pkg::SZW-1:0] size_x_q, size_y_q, size_z_q;
  logic                     front_busy, push, full, pop, empty, wr_en;
  pbei_pkg::plane_t         rec, head;

  // configuration registers
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= pbei_pkg::SZW'(512);
      size_y_q <= pbei_pkg::SZW'(512);
      size_z_q <= pbei_pkg::SZW'(512);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SIZE_X: size_x_q <= pwdata[pbei_pkg::SZW-1:0];
        REG_SIZE_Y: size_y_q <= pwdata[pbei_pkg::SZW-1:0];
        REG_SIZE_Z: size_z_q <= pwdata[pbei_pkg::SZW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = 32'(size_x_q);
      REG_SIZE_Y: prdata = 32'(size_y_q);
      REG_SIZE_Z: prdata = 32'(size_z_q);
      default:    prdata = '0;
    endcase
  end

  assign busy = front_busy;

  pbei_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .plane_i (plane_i),
    .busy_o  (front_busy),
    .push_o  (push),
    .rec_o   (rec),
    .full_i  (full)
  );

  pbei_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  pbei_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .size_x_i       (size_x_q),
    .size_y_i       (size_y_q),
    .size_z_i       (size_z_q),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== sv/pbei_checker.sv =====
module pbei_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic              result_valid_o,
  input  pbei_pkg::result_t result_o
);

  // an accepted request keeps the front side busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // a result without a point is flagged as the last result of its request
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.point_valid |-> result_o.last)
    else $error("pointless result not marked last");

  // non-coplanar requests carry no point
  a_nocop_nopoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == pbei_pkg::ST_NOT_COPLANAR)
      |-> !result_o.point_valid)
    else $error("point on non-coplanar result");

  // points of one request leave back to back with one status
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last
      |=> result_valid_o && (result_o.status == $past(result_o.status)))
    else $error("result burst broken or status changed");

endmodule

bind plane_box_edge_intersection pbei_checker u_pbei_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
